// File: hw/rtl/scat_pkg.sv
// shared types, sizes and codes for the sparse coordinate accumulate table
// no dependencies
package scat_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int MAX_NODES     = 16384;
    localparam int CELLS         = 8;
    localparam int BANK          = TABLE_ENTRIES / CELLS;
    localparam int CW            = $clog2(CELLS);
    localparam int AW            = $clog2(BANK);
    localparam int IW            = $clog2(TABLE_ENTRIES);
    localparam int NW            = IW + 1;

    localparam logic [1:0] ACT_ACCUM   = 2'd0;
    localparam logic [1:0] ACT_PENALTY = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;

    localparam logic [2:0] ST_MERGED    = 3'd0;
    localparam logic [2:0] ST_APPENDED  = 3'd1;
    localparam logic [2:0] ST_TINY      = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_PENALIZED = 3'd4;
    localparam logic [2:0] ST_NODIAG    = 3'd5;
    localparam logic [2:0] ST_READOK    = 3'd6;
    localparam logic [2:0] ST_BADINDEX  = 3'd7;

    localparam logic [63:0] TINY_BITS   = 64'h39B4_484B_FEEB_C2A0;
    localparam logic [63:0] BIG_BITS    = 64'h4629_3E59_39A0_8CEA;
    localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [62:0] INF_MAG     = 63'h7FF0_0000_0000_0000;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] value_bits;
        logic [15:0] row_index;
        logic [15:0] col_index;
        logic [13:0] bound_node;
        logic [1:0]  bound_dir;
        logic [11:0] entry_index;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [12:0] entry_total;
        logic [15:0] out_row;
        logic [15:0] out_col;
        logic [63:0] out_value_bits;
    } t_rsp;

    typedef struct packed {
        logic [15:0] row;
        logic [15:0] col;
        logic [63:0] value;
    } t_entry;

    typedef struct packed {
        logic          valid;
        logic          last;
        logic          hit;
        logic [AW-1:0] addr;
        logic [CW-1:0] hit_cell;
        logic [63:0]   hit_value;
    } t_tok;

    typedef struct packed {
        logic [15:0]   row;
        logic [15:0]   col;
        logic [NW-1:0] count;
    } t_key;

    typedef struct packed {
        logic          en;
        logic          we;
        logic [CW-1:0] bank;
        logic [AW-1:0] addr;
        t_entry        wdata;
    } t_dir;

endpackage

// File: hw/rtl/sparse_coo_accumulate_table.sv
// sparse coordinate-list store with accumulate, penalty and read; uses scat_pkg, cell, fadd
// accumulate or penalty: a scan through the chain of eight banks, skipped if the table is empty
// a merge then waits for the float adder, longer when the sum cancels to exact zero
// read: a registered bank read; tiny values, bad indexes and out-of-range penalties answer from idle
// one request at a time; busy is high outside idle; requests answered from idle never raise it
// synchronous reset clears the state, entry count and flags; the banks keep their contents
module sparse_coo_accumulate_table (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  scat_pkg::t_req   i_req,
    output logic             o_strobe,
    output scat_pkg::t_rsp   o_rsp
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_SCAN    = 7'b0000010,
        S_RESOLVE = 7'b0000100,
        S_FADD    = 7'b0001000,
        S_WRITE   = 7'b0010000,
        S_READ    = 7'b0100000,
        S_RDOUT   = 7'b1000000
    } t_state;

    t_state                  r_state, n_state;
    scat_pkg::t_req          r_req, n_req;
    logic [scat_pkg::NW-1:0] r_count, n_count;
    logic [scat_pkg::NW-1:0] r_nrows, n_nrows;
    logic [15:0]             r_krow, n_krow, r_kcol, n_kcol;
    logic                    r_found, n_found;
    logic [scat_pkg::AW-1:0] r_hit_addr, n_hit_addr;
    logic [scat_pkg::CW-1:0] r_hit_cell, n_hit_cell;
    logic [63:0]             r_hit_value, n_hit_value;
    logic                    r_issuing, n_issuing;
    logic [scat_pkg::AW-1:0] r_iss_addr, n_iss_addr;
    scat_pkg::t_dir          r_dir, n_dir;
    logic                    r_strobe, n_strobe;
    scat_pkg::t_rsp          r_rsp, n_rsp;

    scat_pkg::t_tok          tok [scat_pkg::CELLS + 1];
    scat_pkg::t_entry        rd  [scat_pkg::CELLS];
    scat_pkg::t_key          key;
    scat_pkg::t_tok          end_tok;
    scat_pkg::t_entry        rsel;

    logic        fa_start, fa_done;
    logic [63:0] fa_sum;

    logic [15:0] ord_row, ord_col;
    logic        not_tiny;
    logic [16:0] dof;
    logic        pen_bad;
    logic [31:0] ridx;
    logic        iss_last;

    assign key = '{row: r_krow, col: r_kcol, count: r_count};
    assign iss_last = (scat_pkg::NW'(r_iss_addr) == (r_nrows - scat_pkg::NW'(1)));

    always_comb begin
        tok[0] = '0;
        tok[0].valid = r_issuing;
        tok[0].last  = iss_last;
        tok[0].addr  = r_iss_addr;
    end

    for (genvar k = 0; k < scat_pkg::CELLS; k++) begin : g_cell
        scat_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_id   (scat_pkg::CW'(k)),
            .i_key  (key),
            .i_dir  (r_dir),
            .i_tok  (tok[k]),
            .o_tok  (tok[k + 1]),
            .o_rdata(rd[k])
        );
    end

    assign end_tok = tok[scat_pkg::CELLS];
    assign rsel    = rd[r_dir.bank];

    scat_fadd u_fadd (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(fa_start),
        .i_a    (r_hit_value),
        .i_b    (r_req.value_bits),
        .o_done (fa_done),
        .o_sum  (fa_sum)
    );

    always_comb begin
        n_state = r_state;
        n_req = r_req;
        n_count = r_count;
        n_nrows = r_nrows;
        n_krow = r_krow;
        n_kcol = r_kcol;
        n_found = r_found;
        n_hit_addr = r_hit_addr;
        n_hit_cell = r_hit_cell;
        n_hit_value = r_hit_value;
        n_issuing = r_issuing;
        n_iss_addr = r_iss_addr;
        n_dir = r_dir;
        n_dir.en = 1'b0;
        n_dir.we = 1'b0;
        n_strobe = 1'b0;
        n_rsp = r_rsp;
        fa_start = 1'b0;

        ord_row  = (i_req.row_index >= i_req.col_index) ? i_req.row_index : i_req.col_index;
        ord_col  = (i_req.row_index >= i_req.col_index) ? i_req.col_index : i_req.row_index;
        not_tiny = (i_req.value_bits[62:0] > scat_pkg::TINY_BITS[62:0])
                && (i_req.value_bits[62:0] <= scat_pkg::INF_MAG);
        dof      = ({3'd0, i_req.bound_node} << 1) + {3'd0, i_req.bound_node}
                 + {15'd0, i_req.bound_dir};
        pen_bad  = (i_req.bound_dir == 2'd3)
                || (32'(i_req.bound_node) >= 32'(scat_pkg::MAX_NODES)) || dof[16];
        ridx     = 32'(i_req.entry_index);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    n_found = 1'b0;
                    n_nrows = (r_count + scat_pkg::NW'(scat_pkg::CELLS - 1)) >> scat_pkg::CW;
                    n_iss_addr = '0;
                    n_rsp.entry_total = 13'(r_count);
                    case (i_req.action)
                        scat_pkg::ACT_ACCUM: begin
                            n_krow = ord_row;
                            n_kcol = ord_col;
                            if (!not_tiny) begin
                                n_strobe = 1'b1;
                                n_rsp.status = scat_pkg::ST_TINY;
                                n_rsp.out_row = ord_row;
                                n_rsp.out_col = ord_col;
                                n_rsp.out_value_bits = i_req.value_bits;
                            end else if (r_count == '0) begin
                                n_state = S_RESOLVE;
                            end else begin
                                n_issuing = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        scat_pkg::ACT_PENALTY: begin
                            n_krow = dof[15:0];
                            n_kcol = dof[15:0];
                            if (pen_bad) begin
                                n_strobe = 1'b1;
                                n_rsp.status = scat_pkg::ST_NODIAG;
                                n_rsp.out_row = '0;
                                n_rsp.out_col = '0;
                                n_rsp.out_value_bits = '0;
                            end else if (r_count == '0) begin
                                n_state = S_RESOLVE;
                            end else begin
                                n_issuing = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        scat_pkg::ACT_READ: begin
                            if (ridx < 32'(r_count)) begin
                                n_dir.en = 1'b1;
                                n_dir.bank = ridx[scat_pkg::CW-1:0];
                                n_dir.addr = ridx[scat_pkg::IW-1:scat_pkg::CW];
                                n_state = S_READ;
                            end else begin
                                n_strobe = 1'b1;
                                n_rsp.status = scat_pkg::ST_BADINDEX;
                                n_rsp.out_row = '0;
                                n_rsp.out_col = '0;
                                n_rsp.out_value_bits = '0;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_rsp.status = scat_pkg::ST_BADINDEX;
                            n_rsp.out_row = '0;
                            n_rsp.out_col = '0;
                            n_rsp.out_value_bits = '0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_issuing) begin
                    if (iss_last) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_iss_addr = r_iss_addr + scat_pkg::AW'(1);
                    end
                end
                if (end_tok.valid && end_tok.hit && !r_found) begin
                    n_found = 1'b1;
                    n_hit_addr = end_tok.addr;
                    n_hit_cell = end_tok.hit_cell;
                    n_hit_value = end_tok.hit_value;
                end
                if (end_tok.valid && end_tok.last) begin
                    n_state = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                n_rsp.out_row = r_krow;
                n_rsp.out_col = r_kcol;
                n_rsp.entry_total = 13'(r_count);
                if (r_req.action == scat_pkg::ACT_ACCUM) begin
                    if (r_found) begin
                        fa_start = 1'b1;
                        n_state = S_FADD;
                    end else if (r_count >= scat_pkg::NW'(scat_pkg::TABLE_ENTRIES)) begin
                        n_strobe = 1'b1;
                        n_rsp.status = scat_pkg::ST_FULL;
                        n_rsp.out_value_bits = r_req.value_bits;
                        n_state = S_IDLE;
                    end else begin
                        n_dir.en = 1'b1;
                        n_dir.we = 1'b1;
                        n_dir.bank = r_count[scat_pkg::CW-1:0];
                        n_dir.addr = r_count[scat_pkg::IW-1:scat_pkg::CW];
                        n_dir.wdata = '{row: r_krow, col: r_kcol, value: r_req.value_bits};
                        n_count = r_count + scat_pkg::NW'(1);
                        n_strobe = 1'b1;
                        n_rsp.status = scat_pkg::ST_APPENDED;
                        n_rsp.entry_total = 13'(r_count + scat_pkg::NW'(1));
                        n_rsp.out_value_bits = r_req.value_bits;
                        n_state = S_WRITE;
                    end
                end else begin
                    if (r_found) begin
                        n_dir.en = 1'b1;
                        n_dir.we = 1'b1;
                        n_dir.bank = r_hit_cell;
                        n_dir.addr = r_hit_addr;
                        n_dir.wdata = '{row: r_krow, col: r_kcol, value: scat_pkg::BIG_BITS};
                        n_strobe = 1'b1;
                        n_rsp.status = scat_pkg::ST_PENALIZED;
                        n_rsp.out_value_bits = scat_pkg::BIG_BITS;
                        n_state = S_WRITE;
                    end else begin
                        n_strobe = 1'b1;
                        n_rsp.status = scat_pkg::ST_NODIAG;
                        n_rsp.out_value_bits = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            S_FADD: begin
                if (fa_done) begin
                    n_dir.en = 1'b1;
                    n_dir.we = 1'b1;
                    n_dir.bank = r_hit_cell;
                    n_dir.addr = r_hit_addr;
                    n_dir.wdata = '{row: r_krow, col: r_kcol, value: fa_sum};
                    n_strobe = 1'b1;
                    n_rsp.status = scat_pkg::ST_MERGED;
                    n_rsp.out_value_bits = fa_sum;
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_state = S_IDLE;
            end
            S_READ: begin
                n_state = S_RDOUT;
            end
            S_RDOUT: begin
                n_strobe = 1'b1;
                n_rsp.status = scat_pkg::ST_READOK;
                n_rsp.out_row = rsel.row;
                n_rsp.out_col = rsel.col;
                n_rsp.out_value_bits = rsel.value;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_found <= 1'b0;
            r_issuing <= 1'b0;
            r_dir <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_found <= n_found;
            r_issuing <= n_issuing;
            r_dir <= n_dir;
            r_strobe <= n_strobe;
        end
        r_req <= n_req;
        r_nrows <= n_nrows;
        r_krow <= n_krow;
        r_kcol <= n_kcol;
        r_hit_addr <= n_hit_addr;
        r_hit_cell <= n_hit_cell;
        r_hit_value <= n_hit_value;
        r_iss_addr <= n_iss_addr;
        r_rsp <= n_rsp;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

// File: hw/rtl/scat_ram.sv
// generic single-port ram with registered read
// no dependencies
module scat_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/scat_cell.sv
// one bank of the entry store plus its compare stage in the scan chain
// depends on scat_pkg and scat_ram
module scat_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [scat_pkg::CW-1:0] i_id,
    input  scat_pkg::t_key         i_key,
    input  scat_pkg::t_dir         i_dir,
    input  scat_pkg::t_tok         i_tok,
    output scat_pkg::t_tok         o_tok,
    output scat_pkg::t_entry       o_rdata
);

    scat_pkg::t_tok   r_t1;
    scat_pkg::t_tok   r_t2;
    scat_pkg::t_tok   n_t2;
    scat_pkg::t_entry rdata;
    logic [scat_pkg::AW-1:0] ram_addr;
    logic                    ram_we;
    logic [scat_pkg::NW-1:0] idx;

    assign ram_addr = i_dir.en ? i_dir.addr : i_tok.addr;
    assign ram_we   = i_dir.en & i_dir.we & (i_dir.bank == i_id);

    scat_ram #(
        .WIDTH($bits(scat_pkg::t_entry)),
        .DEPTH(scat_pkg::BANK)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(i_dir.wdata),
        .o_rdata(rdata)
    );

    assign idx = {1'b0, r_t1.addr, i_id};

    always_comb begin
        n_t2 = r_t1;
        if (r_t1.valid && !r_t1.hit && (idx < i_key.count)
                && (rdata.row == i_key.row) && (rdata.col == i_key.col)) begin
            n_t2.hit       = 1'b1;
            n_t2.hit_cell  = i_id;
            n_t2.hit_value = rdata.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_t2 <= '0;
        end else begin
            r_t1 <= i_tok;
            r_t2 <= n_t2;
        end
    end

    assign o_tok   = r_t2;
    assign o_rdata = rdata;

endmodule

// File: hw/rtl/scat_fadd.sv
// multi-cycle ieee double adder, round to nearest even
// depends on scat_pkg
module scat_fadd (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_sum
);

    typedef enum logic [4:0] {
        FA_IDLE  = 5'b00001,
        FA_SETUP = 5'b00010,
        FA_ADD   = 5'b00100,
        FA_NORM  = 5'b01000,
        FA_ROUND = 5'b10000
    } t_fstate;

    t_fstate     r_state, n_state;
    logic [63:0] r_a, r_b, n_a, n_b;
    logic [55:0] r_ma, r_mb, r_s, n_ma, n_mb, n_s;
    logic [11:0] r_e, n_e;
    logic        r_sign, n_sign, r_sub, n_sub;
    logic        r_done, n_done;
    logic [63:0] r_res, n_res;

    logic        a_nan, b_nan, a_inf, b_inf, a_ge;
    logic [63:0] big, sml;
    logic [52:0] mbig, msml;
    logic [11:0] ebig, esml, d;
    logic [5:0]  sh;
    logic [111:0] wide;
    logic [56:0] s57;
    logic [3:0]  lz;
    logic [11:0] sh2;
    logic        up;
    logic [10:0] expf;
    logic [62:0] packed_v;

    always_comb begin
        n_state = r_state;
        n_a = r_a; n_b = r_b;
        n_ma = r_ma; n_mb = r_mb; n_s = r_s;
        n_e = r_e; n_sign = r_sign; n_sub = r_sub;
        n_done = 1'b0;
        n_res = r_res;

        a_nan = (&r_a[62:52]) & (|r_a[51:0]);
        b_nan = (&r_b[62:52]) & (|r_b[51:0]);
        a_inf = (&r_a[62:52]) & ~(|r_a[51:0]);
        b_inf = (&r_b[62:52]) & ~(|r_b[51:0]);
        a_ge  = r_a[62:0] >= r_b[62:0];
        big   = a_ge ? r_a : r_b;
        sml   = a_ge ? r_b : r_a;
        mbig  = {|big[62:52], big[51:0]};
        msml  = {|sml[62:52], sml[51:0]};
        ebig  = (big[62:52] == 11'd0) ? 12'd1 : {1'b0, big[62:52]};
        esml  = (sml[62:52] == 11'd0) ? 12'd1 : {1'b0, sml[62:52]};
        d     = ebig - esml;
        sh    = (d > 12'd63) ? 6'd63 : d[5:0];
        wide  = {msml, 3'b000, 56'd0} >> sh;

        s57 = r_sub ? ({1'b0, r_ma} - {1'b0, r_mb}) : ({1'b0, r_ma} + {1'b0, r_mb});

        lz = 4'd8;
        for (int i = 0; i < 8; i++) begin
            if (r_s[48 + i]) begin
                lz = 4'(7 - i);
            end
        end
        sh2 = ({8'd0, lz} > (r_e - 12'd1)) ? (r_e - 12'd1) : {8'd0, lz};

        up       = r_s[2] & ((|r_s[1:0]) | r_s[3]);
        expf     = r_s[55] ? r_e[10:0] : 11'd0;
        packed_v = {expf, r_s[54:3]} + 63'(up);

        case (r_state)
            FA_IDLE: begin
                if (i_start) begin
                    n_a = i_a;
                    n_b = i_b;
                    n_state = FA_SETUP;
                end
            end
            FA_SETUP: begin
                if (a_nan) begin
                    n_res = r_a | 64'h0008_0000_0000_0000;
                    n_done = 1'b1;
                    n_state = FA_IDLE;
                end else if (b_nan) begin
                    n_res = r_b | 64'h0008_0000_0000_0000;
                    n_done = 1'b1;
                    n_state = FA_IDLE;
                end else if (a_inf && b_inf && (r_a[63] != r_b[63])) begin
                    n_res = scat_pkg::DEFAULT_NAN;
                    n_done = 1'b1;
                    n_state = FA_IDLE;
                end else if (a_inf) begin
                    n_res = r_a;
                    n_done = 1'b1;
                    n_state = FA_IDLE;
                end else if (b_inf) begin
                    n_res = r_b;
                    n_done = 1'b1;
                    n_state = FA_IDLE;
                end else begin
                    n_ma   = {mbig, 3'b000};
                    n_mb   = wide[111:56] | {55'd0, |wide[55:0]};
                    n_e    = ebig;
                    n_sign = big[63];
                    n_sub  = big[63] ^ sml[63];
                    n_state = FA_ADD;
                end
            end
            FA_ADD: begin
                if (s57[56]) begin
                    n_s = {s57[56:2], s57[1] | s57[0]};
                    n_e = r_e + 12'd1;
                end else begin
                    n_s = s57[55:0];
                end
                if (r_sub && (s57 == 57'd0)) begin
                    n_sign = 1'b0;
                end
                n_state = FA_NORM;
            end
            FA_NORM: begin
                if (r_s[55] || (r_e == 12'd1)) begin
                    n_state = FA_ROUND;
                end else if ((lz == 4'd8) && (r_e > 12'd8)) begin
                    n_s = r_s << 8;
                    n_e = r_e - 12'd8;
                end else begin
                    n_s = r_s << sh2[3:0];
                    n_e = r_e - sh2;
                    n_state = FA_ROUND;
                end
            end
            FA_ROUND: begin
                if (r_e >= 12'd2047) begin
                    n_res = {r_sign, 11'h7FF, 52'd0};
                end else begin
                    n_res = {r_sign, packed_v};
                end
                n_done = 1'b1;
                n_state = FA_IDLE;
            end
            default: begin
                n_state = FA_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FA_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_a <= n_a; r_b <= n_b;
        r_ma <= n_ma; r_mb <= n_mb; r_s <= n_s;
        r_e <= n_e; r_sign <= n_sign; r_sub <= n_sub;
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_sum  = r_res;

endmodule

// File: tb/sv/sparse_coo_accumulate_table_tb.sv
// testbench for sparse_coo_accumulate_table: directed and random requests
// checked against a scoreboard that keeps its own copy of the sparse store
// depends on scat_pkg and the sparse_coo_accumulate_table rtl
`timescale 1ns / 100ps

class scat_scoreboard;
    scat_pkg::t_rsp  pending[$];
    logic [15:0]     row_q[scat_pkg::TABLE_ENTRIES];
    logic [15:0]     col_q[scat_pkg::TABLE_ENTRIES];
    logic [63:0]     val_q[scat_pkg::TABLE_ENTRIES];
    int unsigned     used;
    int unsigned     errors;

    function new();
        used   = 0;
        errors = 0;
    endfunction

    function bit is_nan(logic [63:0] v);
        return v[62:52] == 11'h7FF && v[51:0] != 0;
    endfunction

    // one ieee double add, nan results follow the x86 rules
    function logic [63:0] dbl_sum(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        r = $realtobits($bitstoreal(a) + $bitstoreal(b));
        if (is_nan(r)) begin
            if (is_nan(a))
                r = a | (64'd1 << 51);
            else if (is_nan(b))
                r = b | (64'd1 << 51);
            else
                r = scat_pkg::DEFAULT_NAN;
        end
        return r;
    endfunction

    function void note_request(scat_pkg::t_req q);
        scat_pkg::t_rsp e;
        logic [15:0] r;
        logic [15:0] c;
        logic [63:0] mag;
        int unsigned dof;
        bit          hit;
        e = '0;
        case (q.action)
            scat_pkg::ACT_ACCUM: begin
                r = q.row_index;
                c = q.col_index;
                if (r < c) begin
                    r = q.col_index;
                    c = q.row_index;
                end
                mag = {1'b0, q.value_bits[62:0]};
                e.out_row = r;
                e.out_col = c;
                e.out_value_bits = q.value_bits;
                if (is_nan(mag) || mag <= scat_pkg::TINY_BITS) begin
                    e.status = scat_pkg::ST_TINY;
                end else begin
                    hit = 0;
                    for (int i = 0; i < used; i++) begin
                        if (!hit && row_q[i] == r && col_q[i] == c) begin
                            val_q[i] = dbl_sum(val_q[i], q.value_bits);
                            e.status = scat_pkg::ST_MERGED;
                            e.out_value_bits = val_q[i];
                            hit = 1;
                        end
                    end
                    if (!hit) begin
                        if (used >= scat_pkg::TABLE_ENTRIES) begin
                            e.status = scat_pkg::ST_FULL;
                        end else begin
                            row_q[used] = r;
                            col_q[used] = c;
                            val_q[used] = q.value_bits;
                            used++;
                            e.status = scat_pkg::ST_APPENDED;
                        end
                    end
                end
            end
            scat_pkg::ACT_PENALTY: begin
                e.status = scat_pkg::ST_NODIAG;
                if (q.bound_dir <= 2 && q.bound_node < scat_pkg::MAX_NODES) begin
                    dof = q.bound_node * 3 + q.bound_dir;
                    if (dof <= 16'hFFFF) begin
                        e.out_row = 16'(dof);
                        e.out_col = 16'(dof);
                        for (int i = 0; i < used; i++) begin
                            if (row_q[i] == dof && col_q[i] == dof) begin
                                val_q[i] = scat_pkg::BIG_BITS;
                                e.status = scat_pkg::ST_PENALIZED;
                                e.out_value_bits = scat_pkg::BIG_BITS;
                            end
                        end
                    end
                end
            end
            scat_pkg::ACT_READ: begin
                if (q.entry_index < used) begin
                    e.status = scat_pkg::ST_READOK;
                    e.out_row = row_q[q.entry_index];
                    e.out_col = col_q[q.entry_index];
                    e.out_value_bits = val_q[q.entry_index];
                end else begin
                    e.status = scat_pkg::ST_BADINDEX;
                end
            end
            default: begin
                e.status = scat_pkg::ST_BADINDEX;
            end
        endcase
        e.entry_total = 13'(used);
        pending = {pending, e};
    endfunction

    function void check_result(scat_pkg::t_rsp got);
        scat_pkg::t_rsp e;
        if (pending.size() == 0) begin
            $error("unexpected result status %0d", got.status);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, got.status);
            errors++;
        end
        if (got.entry_total !== e.entry_total) begin
            $error("entry_total expected %0d actual %0d", e.entry_total, got.entry_total);
            errors++;
        end
        if (got.out_row !== e.out_row) begin
            $error("out_row expected %0d actual %0d", e.out_row, got.out_row);
            errors++;
        end
        if (got.out_col !== e.out_col) begin
            $error("out_col expected %0d actual %0d", e.out_col, got.out_col);
            errors++;
        end
        if (got.out_value_bits !== e.out_value_bits) begin
            $error("out_value_bits expected %h actual %h", e.out_value_bits,
                   got.out_value_bits);
            errors++;
        end
    endfunction
endclass

module sparse_coo_accumulate_table_tb;

    localparam int LIMIT = 8_000_000;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    scat_pkg::t_req i_req;
    logic           o_strobe;
    scat_pkg::t_rsp o_rsp;
    int             cycles;

    scat_scoreboard sb;

    sparse_coo_accumulate_table DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("sparse_coo_accumulate_table verification failed");
            $finish;
        end
        if (i_rst_n && o_strobe)
            sb.check_result(o_rsp);
    end

    // drive one request and wait until busy drops; if gap is nonzero, drop start and idle for the gap
    task automatic send(scat_pkg::t_req q, int gap);
        i_req <= q;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_request(q);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic scat_pkg::t_req accum(logic [15:0] r, logic [15:0] c,
                                             logic [63:0] v);
        scat_pkg::t_req q;
        q = '0;
        q.action = scat_pkg::ACT_ACCUM;
        q.row_index = r;
        q.col_index = c;
        q.value_bits = v;
        return q;
    endfunction

    function automatic scat_pkg::t_req penalty(logic [13:0] n, logic [1:0] d);
        scat_pkg::t_req q;
        q = '0;
        q.action = scat_pkg::ACT_PENALTY;
        q.bound_node = n;
        q.bound_dir = d;
        return q;
    endfunction

    function automatic scat_pkg::t_req read_at(logic [11:0] idx);
        scat_pkg::t_req q;
        q = '0;
        q.action = scat_pkg::ACT_READ;
        q.entry_index = idx;
        return q;
    endfunction

    function automatic logic [63:0] rand_value();
        int p;
        p = $urandom_range(0, 99);
        if (p < 6) return {$urandom, $urandom};
        if (p < 10) return {1'($urandom_range(0, 1)), 11'h7FF, 52'd0};
        if (p < 14) return {1'($urandom_range(0, 1)), 63'd0};
        if (p < 18) return scat_pkg::TINY_BITS
                         ^ {1'($urandom_range(0, 1)), 62'd0, 1'($urandom_range(0, 1))};
        if (p < 21) return {1'b0, 11'h7FF, $urandom, 20'($urandom_range(1, 1048575))};
        return {1'($urandom_range(0, 1)), 11'($urandom_range(1003, 1043)), $urandom,
                20'($urandom)};
    endfunction

    function automatic logic [15:0] rand_dof();
        if ($urandom_range(0, 9) < 8) return 16'($urandom_range(0, 11));
        return 16'($urandom);
    endfunction

    function automatic scat_pkg::t_req rand_request();
        scat_pkg::t_req q;
        int   p;
        p = $urandom_range(0, 99);
        if (p < 55) begin
            q = accum(rand_dof(), rand_dof(), rand_value());
        end else if (p < 72) begin
            if ($urandom_range(0, 3) == 0)
                q = penalty(14'($urandom), 2'($urandom));
            else
                q = penalty(14'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
        end else if (p < 95) begin
            q = read_at(12'(($urandom_range(0, 9) < 8) ? $urandom_range(0, sb.used + 2)
                                                      : $urandom));
        end else begin
            q = '0;
            q.action = scat_pkg::ACT_UNUSED;
            q.value_bits = {$urandom, $urandom};
        end
        if ($urandom_range(0, 4) == 0) begin
            q.entry_index = q.action == scat_pkg::ACT_READ ? q.entry_index : 12'($urandom);
            q.bound_node = q.action == scat_pkg::ACT_PENALTY ? q.bound_node : 14'($urandom);
        end
        return q;
    endfunction

    initial begin
        scat_pkg::t_req q;
        sb = new();
        cycles = 0;
        start = 1'b0;
        i_req = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        send(read_at(12'd0), 0);
        send(penalty(14'd0, 2'd0), 1);
        send(accum(16'hFFFF, 16'd0, 64'h3FF0_0000_0000_0000), 0);
        send(accum(16'd0, 16'hFFFF, 64'hC000_0000_0000_0000), 2);
        send(accum(16'd3, 16'd3, 64'h4008_0000_0000_0000), 0);
        send(accum(16'd3, 16'd3, 64'h7FF0_0000_0000_0000), 0);
        send(accum(16'd3, 16'd3, 64'hFFF0_0000_0000_0000), 0);
        send(accum(16'd5, 16'd7, scat_pkg::TINY_BITS), 0);
        send(accum(16'd5, 16'd7, scat_pkg::TINY_BITS | (64'd1 << 63)), 0);
        send(accum(16'd5, 16'd7, scat_pkg::TINY_BITS + 64'd1), 3);
        send(accum(16'd9, 16'd9, 64'h0), 0);
        send(accum(16'd9, 16'd9, 64'h8000_0000_0000_0000), 0);
        send(accum(16'd9, 16'd9, 64'hFFFF_FFFF_FFFF_FFFF), 0);
        send(accum(16'd0, 16'd0, 64'h0000_0000_0000_0001), 0);
        send(accum(16'd0, 16'd0, 64'h7FEF_FFFF_FFFF_FFFF), 0);
        send(penalty(14'd1, 2'd0), 0);
        send(penalty(14'd0, 2'd0), 0);
        send(penalty(14'd16383, 2'd2), 0);
        send(penalty(14'd5, 2'd3), 0);
        send(read_at(12'd1), 0);
        send(read_at(12'd4095), 0);
        q = '0;
        q.action = scat_pkg::ACT_UNUSED;
        send(q, 5);

        drain();
        repeat (30) @(posedge i_clk);

        for (int n = 0; n < 110; n++)
            send(rand_request(), (n % 40 < 10) ? 0 : pick_gap());

        send(accum(16'd65535, 16'd65535, 64'h3FF0_0000_0000_0000), 0);
        send(accum(16'd12, 16'd40000, 64'hBFF0_0000_0000_0000), pick_gap());
        send(accum(16'd3, 16'd3, 64'h3FF0_0000_0000_0000), 0);
        send(penalty(14'd0, 2'd0), 0);
        send(read_at(12'd4095), 0);
        send(read_at(12'd0), 0);
        start <= 1'b0;

        drain();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0)
            $display("sparse_coo_accumulate_table verification clean");
        else
            $display("sparse_coo_accumulate_table verification failed");
        $finish;
    end

endmodule
